### hdl/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants for the rational function evaluator
// Holds the fixed field widths, register indexes and a saturating clamp function.
// ----------------------------------------------------------------------------
package rfe_pkg;

    localparam int unsigned DATA_W         = 32;
    localparam int unsigned DEF_MAX_DEGREE = 3;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned NUM_REGS       = 7;
    localparam int unsigned CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_0 = 3'd0,
        REG_NUM_1 = 3'd1,
        REG_NUM_2 = 3'd2,
        REG_NUM_3 = 3'd3,
        REG_DEN_1 = 3'd4,
        REG_DEN_2 = 3'd5,
        REG_DEN_3 = 3'd6,
        REG_NONE  = 3'd7
    } t_cfg_idx;

    // Clamp a 65-bit signed value to the 32-bit range.
    function automatic logic [DATA_W:0] sat32(input logic signed [64:0] v);
        logic [DATA_W:0] r;
        if (v > 65'sh0_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -65'sh0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

### hdl/rational_function_evaluator.sv
// ----------------------------------------------------------------------------
// rational_function_evaluator: P(x)/Q(x) in signed fixed point
//
//  channel   | dir | tdata fields (low bit up)             | tuser
//  s_axis    | in  | sample_x[31:0]                          | -
//  m_axis    | out | ratio_value[31:0]                       | pole_flag, saturated_flag
//  cfg       | in  | wr_en, wr_idx (0..6), wr_data[31:0]     | -
//
// One request per cycle while the output is not stalled; the pipeline holds
// MAX_DEGREE+1 Horner stages, 32+F+1 divider stages (a load stage, then one
// quotient bit per stage) and the output register. The whole pipeline advances
// only when the output register can take a result, so stalls lose nothing.
// Reset clears all valid bits and sets every coefficient to zero.
// ----------------------------------------------------------------------------
module rational_function_evaluator #(
    parameter int unsigned MAX_DEGREE = rfe_pkg::DEF_MAX_DEGREE,
    parameter int unsigned FRAC_BITS  = rfe_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // sample_x
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // ratio_value
    output logic [1:0]                    m_axis_tuser,  // pole_flag, saturated_flag
    input  logic                          i_cfg_wr_en,
    input  logic [rfe_pkg::CFG_IDX_W-1:0] i_cfg_wr_idx,
    input  logic [31:0]                   i_cfg_wr_data
);
    import rfe_pkg::*;

    logic signed [31:0] r_num_c [4];
    logic signed [31:0] r_den_c [4];
    logic               w_en;

    logic               s_vld [MAX_DEGREE+2];
    logic signed [31:0] s_x   [MAX_DEGREE+2];
    logic signed [31:0] s_p   [MAX_DEGREE+2];
    logic signed [31:0] s_q   [MAX_DEGREE+2];
    logic               s_sat [MAX_DEGREE+2];

    logic        d_vld, d_pole, d_sat;
    logic [31:0] d_ratio;
    logic        r_ovld, r_opole, r_osat;
    logic [31:0] r_oratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_num_c[k] <= '0;
                r_den_c[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_wr_idx))
                REG_NUM_0: r_num_c[0] <= i_cfg_wr_data;
                REG_NUM_1: r_num_c[1] <= i_cfg_wr_data;
                REG_NUM_2: r_num_c[2] <= i_cfg_wr_data;
                REG_NUM_3: r_num_c[3] <= i_cfg_wr_data;
                REG_DEN_1: r_den_c[1] <= i_cfg_wr_data;
                REG_DEN_2: r_den_c[2] <= i_cfg_wr_data;
                REG_DEN_3: r_den_c[3] <= i_cfg_wr_data;
                default:   ;
            endcase
        end
    end

    // Pipeline moves whenever the output slot is free or being emptied.
    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign s_vld[0] = s_axis_tvalid;
    assign s_x[0]   = s_axis_tdata;
    assign s_p[0]   = '0;
    assign s_q[0]   = '0;
    assign s_sat[0] = 1'b0;

    for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_horner
        localparam int unsigned J = MAX_DEGREE - g;
        logic signed [31:0] w_pc, w_qc;
        if (J == 0) begin : g_c0
            assign w_pc = r_num_c[0];
            assign w_qc = 32'sd1 <<< FRAC_BITS;
        end else if (J <= 3) begin : g_cj
            assign w_pc = r_num_c[J[1:0]];
            assign w_qc = r_den_c[J[1:0]];
        end else begin : g_cz
            assign w_pc = '0;
            assign w_qc = '0;
        end
        rfe_horner_step #(.FRAC_BITS(FRAC_BITS)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(s_vld[g]), .i_x(s_x[g]), .i_p(s_p[g]), .i_q(s_q[g]),
            .i_sat(s_sat[g]), .i_pc(w_pc), .i_qc(w_qc),
            .o_valid(s_vld[g+1]), .o_x(s_x[g+1]), .o_p(s_p[g+1]),
            .o_q(s_q[g+1]), .o_sat(s_sat[g+1])
        );
    end

    rfe_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(s_vld[MAX_DEGREE+1]), .i_p(s_p[MAX_DEGREE+1]),
        .i_q(s_q[MAX_DEGREE+1]), .i_sat(s_sat[MAX_DEGREE+1]),
        .o_valid(d_vld), .o_ratio(d_ratio), .o_pole(d_pole), .o_sat(d_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= d_vld;
        end
        if (w_en) begin
            r_oratio <= d_ratio;
            r_opole  <= d_pole;
            r_osat   <= d_sat;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_oratio;
    assign m_axis_tuser  = {r_osat, r_opole};

`ifndef ASSERT_OFF
    a_pole_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("pole result carries nonzero value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
`endif
endmodule

### hdl/rfe_horner_step.sv
// ----------------------------------------------------------------------------
// rfe_horner_step: one registered Horner step for numerator and denominator
// Forms acc*x, shifts it down arithmetically, adds the coefficient, saturates.
// ----------------------------------------------------------------------------
module rfe_horner_step #(
    parameter int unsigned FRAC_BITS = rfe_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [31:0]          i_x,
    input  logic signed [31:0]          i_p,
    input  logic signed [31:0]          i_q,
    input  logic                        i_sat,
    input  logic signed [31:0]          i_pc,
    input  logic signed [31:0]          i_qc,
    output logic                        o_valid,
    output logic signed [31:0]          o_x,
    output logic signed [31:0]          o_p,
    output logic signed [31:0]          o_q,
    output logic                        o_sat
);
    import rfe_pkg::*;

    logic signed [63:0] n_pm, n_qm;
    logic signed [64:0] n_ps, n_qs;
    logic [DATA_W:0]    n_pr, n_qr;
    logic               r_valid;
    logic signed [31:0] r_x, r_p, r_q;
    logic               r_sat;

    always_comb begin
        n_pm = i_p * i_x;
        n_qm = i_q * i_x;
        n_ps = 65'(n_pm >>> FRAC_BITS) + 65'(i_pc);
        n_qs = 65'(n_qm >>> FRAC_BITS) + 65'(i_qc);
        n_pr = sat32(n_ps);
        n_qr = sat32(n_qs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x   <= i_x;
            r_p   <= n_pr[DATA_W-1:0];
            r_q   <= n_qr[DATA_W-1:0];
            r_sat <= i_sat | n_pr[DATA_W] | n_qr[DATA_W];
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_sat   = r_sat;
endmodule

### hdl/rfe_divider.sv
// ----------------------------------------------------------------------------
// rfe_divider: pipelined restoring divider for (P * 2^F) / Q
// Works on magnitudes, one quotient bit per stage, then applies sign and clamp.
// ----------------------------------------------------------------------------
module rfe_divider #(
    parameter int unsigned FRAC_BITS = rfe_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_p,
    input  logic signed [31:0] i_q,
    input  logic               i_sat,
    output logic               o_valid,
    output logic [31:0]        o_ratio,
    output logic               o_pole,
    output logic               o_sat
);
    import rfe_pkg::*;

    // Dividend magnitude fits 31+F+1 bits; iterate over every bit.
    localparam int unsigned NW = DATA_W + FRAC_BITS;

    logic [NW-1:0] r_num  [NW+1];
    logic [NW:0]   r_rem  [NW+1];
    logic [31:0]   r_den  [NW+1];
    logic          r_neg  [NW+1];
    logic          r_pole [NW+1];
    logic          r_sat  [NW+1];
    logic          r_vld  [NW+1];

    logic [31:0]   n_pa, n_qa;
    logic [NW:0]   n_trial [NW];
    logic [NW-1:0] n_mag;
    logic [NW:0]   n_lim;
    logic          n_ovf;
    logic [31:0]   n_res;

    always_comb begin
        n_pa = i_p[31] ? 32'(-i_p) : 32'(i_p);
        n_qa = i_q[31] ? 32'(-i_q) : 32'(i_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_num[0]  <= NW'(n_pa) << FRAC_BITS;
            r_rem[0]  <= '0;
            r_den[0]  <= n_qa;
            r_neg[0]  <= i_p[31] ^ i_q[31];
            r_pole[0] <= (i_q == 32'sd0);
            r_sat[0]  <= i_sat;
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_div
        always_comb begin
            n_trial[s] = {r_rem[s][NW-1:0], r_num[s][NW-1]} - (NW+1)'(r_den[s]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                if (!n_trial[s][NW]) begin
                    r_rem[s+1] <= n_trial[s];
                    r_num[s+1] <= {r_num[s][NW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= {r_rem[s][NW-1:0], r_num[s][NW-1]};
                    r_num[s+1] <= {r_num[s][NW-2:0], 1'b0};
                end
                r_den[s+1]  <= r_den[s];
                r_neg[s+1]  <= r_neg[s];
                r_pole[s+1] <= r_pole[s];
                r_sat[s+1]  <= r_sat[s];
            end
        end
    end

    always_comb begin
        n_mag = r_num[NW];
        n_lim = r_neg[NW] ? (NW+1)'(33'h0_8000_0000) : (NW+1)'(33'h0_7FFF_FFFF);
        n_ovf = ({1'b0, n_mag} > n_lim);
        if (r_pole[NW]) begin
            n_res = '0;
        end else if (n_ovf) begin
            n_res = r_neg[NW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            n_res = r_neg[NW] ? 32'(-n_mag) : n_mag[31:0];
        end
    end

    assign o_valid = r_vld[NW];
    assign o_ratio = n_res;
    assign o_pole  = r_pole[NW];
    assign o_sat   = r_sat[NW] | (n_ovf & ~r_pole[NW]);
endmodule
